@@ design/mwrf_pkg.sv @@
// package for the modbus write-register framer
// holds the sequencer state type, frame constants and the crc-16 byte update
// no dependencies
`default_nettype none

package mwrf_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } mwrf_state_e;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned CrcLen   = 6;

  localparam logic [7:0]  FuncWriteSingle = 8'h06;
  localparam logic [7:0]  PageReset       = 8'h20;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam logic [15:0] CrcInit         = 16'hFFFF;

  // frame positions
  localparam logic [2:0] PosAddr   = 3'd0;
  localparam logic [2:0] PosFunc   = 3'd1;
  localparam logic [2:0] PosPage   = 3'd2;
  localparam logic [2:0] PosRegLo  = 3'd3;
  localparam logic [2:0] PosValHi  = 3'd4;
  localparam logic [2:0] PosValLo  = 3'd5;
  localparam logic [2:0] PosCrcLo  = 3'd6;
  localparam logic [2:0] PosCrcHi  = 3'd7;

  // reflected crc-16, one byte folded in, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/modbus_write_register_framer_core.sv @@
// modbus rtu write-single-register framer, top level
// depends on mwrf_pkg for constants, state type and the crc byte update
// Usage:
//   input channel (in_valid_i/in_ready_o) carries one transaction: device
//   address, register low byte and the 16-bit value to write.
//   output channel (out_valid_o/out_ready_i) returns the eight frame bytes in
//   transmission order: address, 0x06, register page, register low, value
//   high, value low, crc low, crc high; byte_index_o gives the position and
//   last_byte_o marks the crc high byte.
//   config channel (cfg_valid_i/cfg_ready_o) writes the register page byte;
//   it is always ready and is meant to be written only while the block idles.
// Latency and throughput:
//   the first byte is valid the cycle after the input transaction. one byte
//   leaves per cycle while out_ready_i is high; the next input transaction is
//   taken together with the last byte of the current frame, so frames run
//   back to back. the crc is folded in byte by byte by a single crc unit as
//   each of the first six bytes is handed over.
// Reset: page returns to 0x20, the sequencer idles with no byte pending.
// Stall: while out_ready_i is low during a frame the current byte holds and no
//   new input transaction is taken.
`default_nettype none

module modbus_write_register_framer_core
  import mwrf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  // input transactions
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  device_address_i,
  input  wire logic [7:0]  register_low_i,
  input  wire logic [15:0] register_value_i,
  // output transactions
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       frame_byte_o,
  output logic [2:0]       byte_index_o,
  output logic             last_byte_o
);

  mwrf_state_e state_q, state_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  page_q;
  logic [7:0]  addr_q;
  logic [7:0]  reg_lo_q;
  logic [15:0] value_q;

  logic in_fire;
  logic out_fire;
  logic [7:0] cur_byte;

  // config register, always accepted
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= PageReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      page_q <= cfg_data_i;
    end
  end

  // byte selection for the current position
  always_comb begin
    unique case (pos_q)
      PosAddr:  cur_byte = addr_q;
      PosFunc:  cur_byte = FuncWriteSingle;
      PosPage:  cur_byte = page_q;
      PosRegLo: cur_byte = reg_lo_q;
      PosValHi: cur_byte = value_q[15:8];
      PosValLo: cur_byte = value_q[7:0];
      PosCrcLo: cur_byte = crc_q[7:0];
      PosCrcHi: cur_byte = crc_q[15:8];
      default:  cur_byte = addr_q;
    endcase
  end

  assign out_valid_o  = (state_q == ST_SEND);
  assign frame_byte_o = cur_byte;
  assign byte_index_o = pos_q;
  assign last_byte_o  = (pos_q == PosCrcHi);

  assign out_fire = out_valid_o && out_ready_i;
  // idle, or handing over the last byte of the frame this cycle
  assign in_ready_o = (state_q == ST_IDLE) || (out_fire && last_byte_o);
  assign in_fire    = in_valid_i && in_ready_o;

  // sequencer and shared crc unit
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    if (in_fire) begin
      state_d = ST_SEND;
      pos_d   = PosAddr;
      crc_d   = CrcInit;
    end else if (out_fire) begin
      if (last_byte_o) begin
        state_d = ST_IDLE;
        pos_d   = PosAddr;
      end else begin
        pos_d = pos_q + 3'd1;
      end
      // fold the header and data bytes, hold the finished crc
      if (pos_q < PosCrcLo) begin
        crc_d = crc_byte(crc_q, cur_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= PosAddr;
      crc_q   <= CrcInit;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q   <= device_address_i;
      reg_lo_q <= register_low_i;
      value_q  <= register_value_i;
    end
  end

`ifndef SYNTHESIS
  // a new frame always starts at position zero
  a_start_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_valid_o && byte_index_o == PosAddr))
    else $error("frame did not start at byte zero");

  // input is only taken mid-frame together with the last byte
  a_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_ready_o) |-> (out_ready_i && byte_index_o == PosCrcHi))
    else $error("input taken in the middle of a frame");

  // function code sits at position one
  a_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_index_o == PosFunc) |-> (frame_byte_o == FuncWriteSingle))
    else $error("wrong function code");

  // positions advance by one per handed-over byte within a frame
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_byte_o) |=> (byte_index_o == $past(byte_index_o) + 3'd1))
    else $error("byte position skipped");
`endif

endmodule

`default_nettype wire
